// ----- rtl/kinetic_scroll_controller_core_assert.svh -----
// assertion macros used by the port-level checker
`ifndef KINETIC_SCROLL_CONTROLLER_CORE_ASSERT_SVH
`define KINETIC_SCROLL_CONTROLLER_CORE_ASSERT_SVH

// same-cycle implication, sampled on the rising clock edge, quiet during reset
`define KSC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("kinetic scroll check failed");

// next-cycle implication, sampled on the rising clock edge, quiet during reset
`define KSC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("kinetic scroll check failed");

`endif

// ----- rtl/ksc_pkg.sv -----
// types, codes and arithmetic helpers for the kinetic scroll controller
package ksc_pkg;

  // mode codes
  localparam logic [2:0] MODE_STEADY  = 3'd0;
  localparam logic [2:0] MODE_PRESSED = 3'd1;
  localparam logic [2:0] MODE_MANUAL  = 3'd2;
  localparam logic [2:0] MODE_AUTO    = 3'd3;
  localparam logic [2:0] MODE_STOP    = 3'd4;

  // event codes
  localparam logic [1:0] CMD_PRESS   = 2'd0;
  localparam logic [1:0] CMD_RELEASE = 2'd1;
  localparam logic [1:0] CMD_MOVE    = 2'd2;
  localparam logic [1:0] CMD_TICK    = 2'd3;

  // register indexes
  localparam logic [1:0] REG_MAX_SPEED    = 2'd0;
  localparam logic [1:0] REG_DECEL_STEP   = 2'd1;
  localparam logic [1:0] REG_SCROLL_MAX_X = 2'd2;
  localparam logic [1:0] REG_SCROLL_MAX_Y = 2'd3;

  // register reset values
  localparam logic [9:0] MAX_SPEED_RST  = 10'd64;
  localparam logic [7:0] DECEL_STEP_RST = 8'd1;

  typedef struct packed {
    logic [1:0]         cmd;
    logic               left_only;
    logic               no_modifier;
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] cursor_x;
    logic signed [15:0] cursor_y;
  } ksc_in_t;

  typedef struct packed {
    logic        consumed;
    logic        replay_click;
    logic        move_notify;
    logic [15:0] offset_x;
    logic [15:0] offset_y;
    logic [2:0]  mode;
  } ksc_out_t;

  typedef struct packed {
    logic [9:0]  max_speed;
    logic [7:0]  decel_step;
    logic [15:0] scroll_max_x;
    logic [15:0] scroll_max_y;
  } ksc_cfg_t;

  typedef struct packed {
    logic [2:0]         mode;
    logic signed [15:0] press_x;
    logic signed [15:0] press_y;
    logic [15:0]        snap_x;
    logic [15:0]        snap_y;
    logic signed [15:0] drag_x;
    logic signed [15:0] drag_y;
    logic signed [16:0] speed_x;
    logic signed [16:0] speed_y;
    logic [15:0]        scroll_x;
    logic [15:0]        scroll_y;
  } ksc_state_t;

  // clamp velocity to +-max, then move it toward zero by step
  function automatic logic signed [16:0] slow_down(input logic signed [16:0] s,
                                                   input logic [9:0] max_speed,
                                                   input logic [7:0] step);
    logic signed [16:0] m;
    logic signed [16:0] a;
    logic signed [16:0] v;
    logic signed [16:0] d;
    m = signed'({7'd0, max_speed});
    a = signed'({9'd0, step});
    v = s;
    if (v > m) v = m;
    if (v < -m) v = -m;
    if (v > 17'sd0) begin
      d = v - a;
      v = (d > 17'sd0) ? d : 17'sd0;
    end else if (v < 17'sd0) begin
      d = v + a;
      v = (d < 17'sd0) ? d : 17'sd0;
    end
    return v;
  endfunction

  // saturate a signed offset into 0..max
  function automatic logic [15:0] sat_offset(input logic signed [18:0] v,
                                             input logic [15:0] mx);
    logic [15:0] r;
    if (v < 19'sd0) r = 16'd0;
    else if (v > signed'({3'd0, mx})) r = mx;
    else r = v[15:0];
    return r;
  endfunction

endpackage

// ----- rtl/ksc_step.sv -----
// next-state and result logic for one event or tick
module ksc_step (
  input  ksc_pkg::ksc_state_t st,
  input  ksc_pkg::ksc_cfg_t   cfg,
  input  ksc_pkg::ksc_in_t    item,
  output ksc_pkg::ksc_state_t st_next,
  output ksc_pkg::ksc_out_t   res
);
  import ksc_pkg::*;

  logic               consumed;
  logic               replay;
  logic               notify;
  logic signed [16:0] auto_sx;
  logic signed [16:0] auto_sy;
  logic signed [18:0] auto_vx;
  logic signed [18:0] auto_vy;
  logic signed [18:0] drag_vx;
  logic signed [18:0] drag_vy;

  // auto-scroll velocity decay and offset update
  always_comb begin
    auto_sx = slow_down(st.speed_x, cfg.max_speed, cfg.decel_step);
    auto_sy = slow_down(st.speed_y, cfg.max_speed, cfg.decel_step);
    auto_vx = signed'({3'd0, st.scroll_x}) - {{2{auto_sx[16]}}, auto_sx};
    auto_vy = signed'({3'd0, st.scroll_y}) - {{2{auto_sy[16]}}, auto_sy};
  end

  // offset while dragging: snapshot minus pointer travel since press
  always_comb begin
    drag_vx = signed'({3'd0, st.snap_x})
            - ({{3{item.pos_x[15]}}, item.pos_x} - {{3{st.press_x[15]}}, st.press_x});
    drag_vy = signed'({3'd0, st.snap_y})
            - ({{3{item.pos_y[15]}}, item.pos_y} - {{3{st.press_y[15]}}, st.press_y});
  end

  // mode machine
  always_comb begin
    st_next  = st;
    consumed = 1'b0;
    replay   = 1'b0;
    notify   = 1'b0;
    if (item.cmd == CMD_TICK) begin
      if (st.mode == MODE_MANUAL) begin
        st_next.speed_x = {item.cursor_x[15], item.cursor_x}
                        - {st.drag_x[15], st.drag_x};
        st_next.speed_y = {item.cursor_y[15], item.cursor_y}
                        - {st.drag_y[15], st.drag_y};
        st_next.drag_x  = item.cursor_x;
        st_next.drag_y  = item.cursor_y;
      end else if (st.mode == MODE_AUTO) begin
        st_next.speed_x  = auto_sx;
        st_next.speed_y  = auto_sy;
        st_next.scroll_x = sat_offset(auto_vx, cfg.scroll_max_x);
        st_next.scroll_y = sat_offset(auto_vy, cfg.scroll_max_y);
        if (auto_sx == 17'sd0 && auto_sy == 17'sd0) st_next.mode = MODE_STEADY;
      end
    end else if (item.no_modifier) begin
      case (st.mode)
        MODE_STEADY: begin
          if (item.cmd == CMD_PRESS && item.left_only) begin
            consumed        = 1'b1;
            st_next.mode    = MODE_PRESSED;
            st_next.press_x = item.pos_x;
            st_next.press_y = item.pos_y;
            st_next.snap_x  = st.scroll_x;
            st_next.snap_y  = st.scroll_y;
          end else if (item.cmd == CMD_MOVE) begin
            notify = 1'b1;
          end
        end
        MODE_PRESSED: begin
          if (item.cmd == CMD_RELEASE) begin
            consumed     = 1'b1;
            replay       = 1'b1;
            st_next.mode = MODE_STEADY;
          end else if (item.cmd == CMD_MOVE) begin
            consumed       = 1'b1;
            st_next.mode   = MODE_MANUAL;
            st_next.drag_x = item.cursor_x;
            st_next.drag_y = item.cursor_y;
          end
        end
        MODE_MANUAL: begin
          if (item.cmd == CMD_MOVE) begin
            consumed         = 1'b1;
            st_next.scroll_x = sat_offset(drag_vx, cfg.scroll_max_x);
            st_next.scroll_y = sat_offset(drag_vy, cfg.scroll_max_y);
          end else if (item.cmd == CMD_RELEASE) begin
            consumed     = 1'b1;
            st_next.mode = MODE_AUTO;
          end
        end
        MODE_AUTO: begin
          if (item.cmd == CMD_PRESS) begin
            consumed        = 1'b1;
            st_next.mode    = MODE_STOP;
            st_next.speed_x = 17'sd0;
            st_next.speed_y = 17'sd0;
            st_next.press_x = item.pos_x;
            st_next.press_y = item.pos_y;
            st_next.snap_x  = st.scroll_x;
            st_next.snap_y  = st.scroll_y;
          end else if (item.cmd == CMD_RELEASE) begin
            consumed        = 1'b1;
            st_next.mode    = MODE_STEADY;
            st_next.speed_x = 17'sd0;
            st_next.speed_y = 17'sd0;
          end
        end
        MODE_STOP: begin
          if (item.cmd == CMD_RELEASE) begin
            consumed     = 1'b1;
            st_next.mode = MODE_STEADY;
          end else if (item.cmd == CMD_MOVE) begin
            consumed       = 1'b1;
            st_next.mode   = MODE_MANUAL;
            st_next.drag_x = item.cursor_x;
            st_next.drag_y = item.cursor_y;
          end
        end
        default: begin
          st_next = st;
        end
      endcase
    end
  end

  // result beat reflects the state after this event
  always_comb begin
    res.consumed     = consumed;
    res.replay_click = replay;
    res.move_notify  = notify;
    res.offset_x     = st_next.scroll_x;
    res.offset_y     = st_next.scroll_y;
    res.mode         = st_next.mode;
  end

endmodule

// ----- rtl/ksc_out_reg.sv -----
// output register holding one result beat until the consumer takes it
module ksc_out_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  ksc_pkg::ksc_out_t load_data,
  output logic              ready,
  output logic              out_valid,
  input  logic              out_stall,
  output ksc_pkg::ksc_out_t out_data
);
  import ksc_pkg::*;

  // slot is free when empty or being drained this cycle
  assign ready = !out_valid || !out_stall;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= load;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (ready && load) begin
      out_data <= load_data;
    end
  end

endmodule

// ----- rtl/kinetic_scroll_controller_core.sv -----
// Kinetic flick-scroll controller: one event or tick per cycle when not stalled;
// each beat is registered on entry, its mode transition and offset update are
// computed combinationally by the step logic and written to the output register,
// so the input and output registers lie between a beat and its result. Throughput
// is one beat per clock when not stalled, set by the state update loop (velocity
// clamp and decay, offset subtract and saturation) being combinational. The input
// side stalls only while its held beat cannot move into a full, stalled output
// register. Configuration writes take effect at once and clamp the current offset
// when a scroll maximum is lowered; write them only while the block is idle.
module kinetic_scroll_controller_core (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  ksc_pkg::ksc_in_t in_data,
  output logic             out_valid,
  input  logic             out_stall,
  output ksc_pkg::ksc_out_t out_data,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [15:0]      cfg_wdata
);
  import ksc_pkg::*;

  ksc_in_t    item;
  logic       item_valid;
  ksc_state_t st;
  ksc_state_t st_next;
  ksc_cfg_t   cfg;
  ksc_out_t   res;
  logic       out_ready;
  logic       fire;

  assign fire     = item_valid && out_ready;
  assign in_stall = item_valid && !out_ready;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      item_valid <= 1'b1;
    end else if (fire) begin
      item_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      item <= in_data;
    end
  end

  // per-event logic
  ksc_step u_step (
    .st      (st),
    .cfg     (cfg),
    .item    (item),
    .st_next (st_next),
    .res     (res)
  );

  // controller state and configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      // all-zero state is steady mode at offset zero
      st                <= '0;
      cfg.max_speed     <= MAX_SPEED_RST;
      cfg.decel_step    <= DECEL_STEP_RST;
      cfg.scroll_max_x  <= 16'd0;
      cfg.scroll_max_y  <= 16'd0;
    end else begin
      if (fire) begin
        st <= st_next;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_MAX_SPEED:  cfg.max_speed  <= cfg_wdata[9:0];
          REG_DECEL_STEP: cfg.decel_step <= cfg_wdata[7:0];
          REG_SCROLL_MAX_X: begin
            cfg.scroll_max_x <= cfg_wdata;
            if (st.scroll_x > cfg_wdata) st.scroll_x <= cfg_wdata;
          end
          REG_SCROLL_MAX_Y: begin
            cfg.scroll_max_y <= cfg_wdata;
            if (st.scroll_y > cfg_wdata) st.scroll_y <= cfg_wdata;
          end
          default: begin
            cfg <= cfg;
          end
        endcase
      end
    end
  end

  // result register
  ksc_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (fire),
    .load_data (res),
    .ready     (out_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

endmodule

// ----- rtl/ksc_checker.sv -----
// port-level checks for the kinetic scroll controller, bound to the top level
`include "kinetic_scroll_controller_core_assert.svh"

module ksc_checker (
  input logic              clk,
  input logic              rst,
  input logic              out_valid,
  input logic              out_stall,
  input ksc_pkg::ksc_out_t out_data
);
  import ksc_pkg::*;

  // a stalled result beat stays offered and unchanged
  `KSC_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
  `KSC_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_data))

  // a click replay only comes from a swallowed release that returns to steady
  `KSC_ASSERT_NOW(a_replay_steady, out_valid && out_data.replay_click,
    out_data.consumed && out_data.mode == MODE_STEADY)

  // move tracking is reported only for unswallowed moves in steady mode
  `KSC_ASSERT_NOW(a_notify_steady, out_valid && out_data.move_notify,
    !out_data.consumed && !out_data.replay_click && out_data.mode == MODE_STEADY)

endmodule

bind kinetic_scroll_controller_core ksc_checker u_ksc_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// ----- bench/tb_top.sv -----
// self-checking testbench for the kinetic scroll controller core
`timescale 1ns / 1ps

module tb_top;
  import ksc_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int PHASE_ITEMS = 200;
  localparam int PHASES = 8;
  localparam int DRAIN_CYCLES = 4;
  localparam logic [15:0] C_MIN = 16'h8000;
  localparam logic [15:0] C_MAX = 16'h7FFF;

  // one line of the directed plan: a register write or an event beat
  typedef struct {
    bit          is_write;
    logic [1:0]  reg_idx;
    logic [15:0] reg_val;
    ksc_in_t     ev;
    bit          pinned;
    ksc_out_t    res;
  } plan_row_t;

  logic     clk = 1'b0;
  logic     rst = 1'b1;
  logic     in_valid = 1'b0;
  logic     in_stall;
  ksc_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  ksc_out_t out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_wdata = '0;

  // predicted scroller state and limits
  logic [9:0]         lim_speed = MAX_SPEED_RST;
  logic [7:0]         lim_decel = DECEL_STEP_RST;
  logic [15:0]        lim_x = '0;
  logic [15:0]        lim_y = '0;
  logic [2:0]         track_mode = MODE_STEADY;
  logic signed [15:0] grab_x = '0, grab_y = '0, trail_x = '0, trail_y = '0;
  logic [15:0]        base_x = '0, base_y = '0, view_x = '0, view_y = '0;
  logic signed [16:0] vel_x = '0, vel_y = '0;

  ksc_out_t  pending_q[$];
  plan_row_t plan[$];

  int errors = 0;
  int results_seen = 0;
  int items_sent = 0;
  int useful_items = 0;
  int gestures = 0;
  int cfg_writes = 0;
  int cycle_cnt = 0;
  int stall_run = 0;
  bit tx_quiet = 1'b0;
  bit rx_quiet = 1'b0;
  bit [7:0] modes_seen = '0;

  kinetic_scroll_controller_core uut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always #10 clk = ~clk;

  // ---------------------------------------------------------------- helpers

  function automatic ksc_in_t ptr_ev(input logic [1:0] c, input logic l, input logic n,
                                     input logic [15:0] px, input logic [15:0] py,
                                     input logic [15:0] cx, input logic [15:0] cy);
    ksc_in_t e;
    e.cmd = c;
    e.left_only = l;
    e.no_modifier = n;
    e.pos_x = px;
    e.pos_y = py;
    e.cursor_x = cx;
    e.cursor_y = cy;
    return e;
  endfunction

  function automatic ksc_out_t outcome(input logic c, input logic r, input logic n,
                                       input logic [15:0] ox, input logic [15:0] oy,
                                       input logic [2:0] m);
    ksc_out_t o;
    o.consumed = c;
    o.replay_click = r;
    o.move_notify = n;
    o.offset_x = ox;
    o.offset_y = oy;
    o.mode = m;
    return o;
  endfunction

  // mostly short idle runs, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [15:0] coord();
    if ($urandom_range(0, 4) == 0) return 16'($urandom);
    return 16'($urandom_range(0, 2000) - 1000);
  endfunction

  function automatic int nudge();
    if ($urandom_range(0, 9) == 0) return int'(16'($urandom));
    return int'($urandom_range(0, 80)) - 40;
  endfunction

  function automatic logic coin();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic ksc_in_t noise_event();
    return ptr_ev(2'($urandom_range(0, 3)), coin(), coin(), 16'($urandom), 16'($urandom),
                  16'($urandom), 16'($urandom));
  endfunction

  // offset saturation into 0..lim
  function automatic logic [15:0] clamp_offset(input int v, input logic [15:0] lim);
    if (v < 0) return 16'd0;
    if (v > int'(lim)) return lim;
    return v[15:0];
  endfunction

  // velocity clamp to +-limit, then one deceleration step toward zero
  function automatic logic signed [16:0] decay_velocity(input logic signed [16:0] s);
    int v, top, dec;
    v = s;
    top = int'(lim_speed);
    dec = int'(lim_decel);
    if (v > top) v = top;
    if (v < -top) v = -top;
    if (v > 0) v = (v > dec) ? v - dec : 0;
    else if (v < 0) v = (v < -dec) ? v + dec : 0;
    return v[16:0];
  endfunction

  // advance the predicted scroller by one event and give its result
  task automatic apply_event(input ksc_in_t ev, output ksc_out_t res, output bit effective);
    int px, py, cx, cy;
    px = $signed(ev.pos_x);
    py = $signed(ev.pos_y);
    cx = $signed(ev.cursor_x);
    cy = $signed(ev.cursor_y);
    res = '0;
    effective = 1'b0;
    if (ev.cmd == CMD_TICK) begin
      if (track_mode == MODE_MANUAL) begin
        vel_x = 17'(cx - int'(trail_x));
        vel_y = 17'(cy - int'(trail_y));
        trail_x = ev.cursor_x;
        trail_y = ev.cursor_y;
        effective = 1'b1;
      end else if (track_mode == MODE_AUTO) begin
        vel_x = decay_velocity(vel_x);
        vel_y = decay_velocity(vel_y);
        view_x = clamp_offset(int'(view_x) - int'(vel_x), lim_x);
        view_y = clamp_offset(int'(view_y) - int'(vel_y), lim_y);
        if (vel_x == 0 && vel_y == 0) track_mode = MODE_STEADY;
        effective = 1'b1;
      end
    end else if (ev.no_modifier) begin
      case (track_mode)
        MODE_STEADY: begin
          if (ev.cmd == CMD_PRESS && ev.left_only) begin
            res.consumed = 1'b1;
            track_mode = MODE_PRESSED;
            grab_x = ev.pos_x;
            grab_y = ev.pos_y;
            base_x = view_x;
            base_y = view_y;
          end else if (ev.cmd == CMD_MOVE) begin
            res.move_notify = 1'b1;
          end
        end
        MODE_PRESSED: begin
          if (ev.cmd == CMD_RELEASE) begin
            res.consumed = 1'b1;
            res.replay_click = 1'b1;
            track_mode = MODE_STEADY;
          end else if (ev.cmd == CMD_MOVE) begin
            res.consumed = 1'b1;
            track_mode = MODE_MANUAL;
            trail_x = ev.cursor_x;
            trail_y = ev.cursor_y;
          end
        end
        MODE_MANUAL: begin
          if (ev.cmd == CMD_MOVE) begin
            res.consumed = 1'b1;
            view_x = clamp_offset(int'(base_x) - (px - int'(grab_x)), lim_x);
            view_y = clamp_offset(int'(base_y) - (py - int'(grab_y)), lim_y);
          end else if (ev.cmd == CMD_RELEASE) begin
            res.consumed = 1'b1;
            track_mode = MODE_AUTO;
          end
        end
        MODE_AUTO: begin
          // a catch in flight does not look at the button mask
          if (ev.cmd == CMD_PRESS) begin
            res.consumed = 1'b1;
            track_mode = MODE_STOP;
            vel_x = '0;
            vel_y = '0;
            grab_x = ev.pos_x;
            grab_y = ev.pos_y;
            base_x = view_x;
            base_y = view_y;
          end else if (ev.cmd == CMD_RELEASE) begin
            res.consumed = 1'b1;
            track_mode = MODE_STEADY;
            vel_x = '0;
            vel_y = '0;
          end
        end
        MODE_STOP: begin
          if (ev.cmd == CMD_RELEASE) begin
            res.consumed = 1'b1;
            track_mode = MODE_STEADY;
          end else if (ev.cmd == CMD_MOVE) begin
            res.consumed = 1'b1;
            track_mode = MODE_MANUAL;
            trail_x = ev.cursor_x;
            trail_y = ev.cursor_y;
          end
        end
        default: begin
        end
      endcase
      effective = res.consumed | res.move_notify;
    end
    res.offset_x = view_x;
    res.offset_y = view_y;
    res.mode = track_mode;
  endtask

  // ------------------------------------------------------------ plan entries

  task automatic plan_event(input ksc_in_t ev);
    plan_row_t row;
    row = '{is_write: 1'b0, reg_idx: '0, reg_val: '0, ev: ev, pinned: 1'b0, res: '0};
    plan.push_back(row);
  endtask

  task automatic plan_check(input ksc_in_t ev, input ksc_out_t res);
    plan_row_t row;
    row = '{is_write: 1'b0, reg_idx: '0, reg_val: '0, ev: ev, pinned: 1'b1, res: res};
    plan.push_back(row);
  endtask

  task automatic plan_write(input logic [1:0] idx, input logic [15:0] val);
    plan_row_t row;
    row = '{is_write: 1'b1, reg_idx: idx, reg_val: val, ev: '0, pinned: 1'b0, res: '0};
    plan.push_back(row);
  endtask

  // ---------------------------------------------------------------- driving

  // drop valid and wait until every predicted result has been seen
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // register write on an idle block, mirrored into the predictor
  task automatic set_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_writes++;
    case (idx)
      REG_MAX_SPEED: lim_speed = val[9:0];
      REG_DECEL_STEP: lim_decel = val[7:0];
      REG_SCROLL_MAX_X: begin
        lim_x = val;
        if (view_x > lim_x) view_x = lim_x;
      end
      REG_SCROLL_MAX_Y: begin
        lim_y = val;
        if (view_y > lim_y) view_y = lim_y;
      end
      default: begin
      end
    endcase
  endtask

  // send one beat, then queue its predicted (or pinned) result
  task automatic send_event(input ksc_in_t ev, input bit pinned, input ksc_out_t pinned_res);
    int gap;
    ksc_out_t res;
    bit effective;
    gap = tx_quiet ? 0 : idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= ev;
    do @(posedge clk); while (in_stall);
    apply_event(ev, res, effective);
    if (pinned) res = pinned_res;
    pending_q.push_back(res);
    items_sent++;
    if (effective) useful_items++;
  endtask

  // press, drag with velocity samples, release, then ride or catch the flick
  task automatic flick_gesture();
    logic [15:0] px, py, cx, cy;
    int steps, ticks;
    px = coord();
    py = coord();
    cx = coord();
    cy = coord();
    gestures++;
    send_event(ptr_ev(CMD_PRESS, 1'b1, 1'b1, px, py, cx, cy), 1'b0, '0);
    steps = $urandom_range(1, 8);
    repeat (steps) begin
      px = px + 16'(nudge());
      py = py + 16'(nudge());
      cx = cx + 16'(nudge());
      cy = cy + 16'(nudge());
      send_event(ptr_ev(CMD_MOVE, 1'b1, 1'b1, px, py, cx, cy), 1'b0, '0);
      if ($urandom_range(0, 2) != 0) begin
        cx = cx + 16'(nudge());
        cy = cy + 16'(nudge());
        send_event(ptr_ev(CMD_TICK, coin(), coin(), coord(), coord(), cx, cy), 1'b0, '0);
      end
      if ($urandom_range(0, 19) == 0) send_event(noise_event(), 1'b0, '0);
    end
    send_event(ptr_ev(CMD_RELEASE, coin(), 1'b1, px, py, cx, cy), 1'b0, '0);
    // coast until the velocity dies out, now and then caught by a new press
    ticks = 0;
    while (track_mode == MODE_AUTO && ticks < 150) begin
      ticks++;
      if ($urandom_range(0, 49) == 0) begin
        send_event(ptr_ev(CMD_PRESS, coin(), 1'b1, px, py, cx, cy), 1'b0, '0);
        if (coin()) begin
          px = px + 16'(nudge());
          cx = cx + 16'(nudge());
          send_event(ptr_ev(CMD_MOVE, 1'b1, 1'b1, px, py, cx, cy), 1'b0, '0);
          cy = cy + 16'(nudge());
          send_event(ptr_ev(CMD_TICK, coin(), coin(), px, py, cx, cy), 1'b0, '0);
          py = py + 16'(nudge());
          send_event(ptr_ev(CMD_MOVE, 1'b1, 1'b1, px, py, cx, cy), 1'b0, '0);
        end
        send_event(ptr_ev(CMD_RELEASE, coin(), 1'b1, px, py, cx, cy), 1'b0, '0);
      end else begin
        send_event(ptr_ev(CMD_TICK, coin(), coin(), 16'($urandom), 16'($urandom),
                          16'($urandom), 16'($urandom)), 1'b0, '0);
      end
    end
    if (track_mode == MODE_AUTO)
      send_event(ptr_ev(CMD_RELEASE, coin(), 1'b1, px, py, cx, cy), 1'b0, '0);
  endtask

  // --------------------------------------------------------- result checking

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // compare each accepted result beat with the oldest prediction
  always @(posedge clk) begin : result_check
    ksc_out_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: result beat with nothing expected, expected none, got %p",
                 $time, out_data);
      end else begin
        want = pending_q.pop_front();
        results_seen++;
        modes_seen[out_data.mode] = 1'b1;
        check_field("consumed", want.consumed, out_data.consumed);
        check_field("replay_click", want.replay_click, out_data.replay_click);
        check_field("move_notify", want.move_notify, out_data.move_notify);
        check_field("offset_x", want.offset_x, out_data.offset_x);
        check_field("offset_y", want.offset_y, out_data.offset_y);
        check_field("mode", want.mode, out_data.mode);
      end
    end
  end

  // receiver back-pressure: runs of stall or no stall
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      stall_run <= 0;
    end else if (stall_run > 0) begin
      stall_run <= stall_run - 1;
    end else if (rx_quiet) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < 40);
      stall_run <= idle_len();
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, pending_q.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- stimulus

  initial begin : stimulus
    int ms, dc, mx, my, phase_start;

    // idle behavior right after reset, all offsets pinned at zero
    plan_check(ptr_ev(CMD_TICK, 1'b0, 1'b0, C_MAX, C_MIN, C_MAX, C_MIN),
               outcome(1'b0, 1'b0, 1'b0, 16'd0, 16'd0, MODE_STEADY));
    plan_check(ptr_ev(CMD_MOVE, 1'b1, 1'b1, C_MIN, C_MAX, C_MIN, C_MAX),
               outcome(1'b0, 1'b0, 1'b1, 16'd0, 16'd0, MODE_STEADY));
    // modifier held: press ignored
    plan_check(ptr_ev(CMD_PRESS, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0),
               outcome(1'b0, 1'b0, 1'b0, 16'd0, 16'd0, MODE_STEADY));
    // other buttons down: press not taken, stray release ignored
    plan_check(ptr_ev(CMD_PRESS, 1'b0, 1'b1, 16'd3, 16'd4, 16'd5, 16'd6),
               outcome(1'b0, 1'b0, 1'b0, 16'd0, 16'd0, MODE_STEADY));
    plan_check(ptr_ev(CMD_RELEASE, 1'b1, 1'b1, 16'd3, 16'd4, 16'd5, 16'd6),
               outcome(1'b0, 1'b0, 1'b0, 16'd0, 16'd0, MODE_STEADY));
    // press and release without drag replays as a click
    plan_check(ptr_ev(CMD_PRESS, 1'b1, 1'b1, 16'd10, 16'd20, 16'd30, 16'd40),
               outcome(1'b1, 1'b0, 1'b0, 16'd0, 16'd0, MODE_PRESSED));
    plan_check(ptr_ev(CMD_RELEASE, 1'b1, 1'b1, 16'd10, 16'd20, 16'd30, 16'd40),
               outcome(1'b1, 1'b1, 1'b0, 16'd0, 16'd0, MODE_STEADY));
    // widest speed, step and horizontal limits, vertical limit of 300
    plan_write(REG_MAX_SPEED, 16'd1023);
    plan_write(REG_DECEL_STEP, 16'd255);
    plan_write(REG_SCROLL_MAX_X, 16'hFFFF);
    plan_write(REG_SCROLL_MAX_Y, 16'd300);
    // full-range drag puts both offsets on their rails
    plan_event(ptr_ev(CMD_PRESS, 1'b1, 1'b1, C_MAX, C_MIN, 16'd0, 16'd0));
    plan_event(ptr_ev(CMD_MOVE, 1'b1, 1'b1, C_MAX, C_MIN, C_MIN, C_MAX));
    plan_check(ptr_ev(CMD_MOVE, 1'b1, 1'b1, C_MIN, C_MAX, C_MIN, C_MAX),
               outcome(1'b1, 1'b0, 1'b0, 16'hFFFF, 16'd0, MODE_MANUAL));
    // largest velocity both ways, then one clamped decay step
    plan_event(ptr_ev(CMD_TICK, 1'b0, 1'b0, 16'd0, 16'd0, C_MAX, C_MIN));
    plan_event(ptr_ev(CMD_RELEASE, 1'b1, 1'b1, 16'd0, 16'd0, C_MAX, C_MIN));
    plan_event(ptr_ev(CMD_TICK, 1'b1, 1'b1, 16'd0, 16'd0, 16'd0, 16'd0));
    // catch while coasting without the left-only mask, then a press with no meaning
    plan_event(ptr_ev(CMD_PRESS, 1'b0, 1'b1, 16'd5, 16'd5, 16'd0, 16'd0));
    plan_event(ptr_ev(CMD_PRESS, 1'b1, 1'b1, 16'd9, 16'd9, 16'd0, 16'd0));
    plan_event(ptr_ev(CMD_MOVE, 1'b1, 1'b1, 16'd6, 16'd6, 16'd100, 16'd100));
    plan_event(ptr_ev(CMD_TICK, 1'b1, 1'b1, 16'd0, 16'd0, 16'd107, 16'd91));
    plan_event(ptr_ev(CMD_RELEASE, 1'b1, 1'b1, 16'd6, 16'd6, 16'd107, 16'd91));
    plan_event(ptr_ev(CMD_RELEASE, 1'b1, 1'b1, 16'd6, 16'd6, 16'd107, 16'd91));
    plan_event(ptr_ev(CMD_MOVE, 1'b1, 1'b0, 16'd1, 16'd1, 16'd1, 16'd1));
    // zero speed limit, no deceleration, horizontal limit lowered under the offset
    plan_write(REG_MAX_SPEED, 16'd0);
    plan_write(REG_DECEL_STEP, 16'd0);
    plan_write(REG_SCROLL_MAX_X, 16'd100);
    plan_write(REG_SCROLL_MAX_Y, 16'hFFFF);
    plan_event(ptr_ev(CMD_PRESS, 1'b1, 1'b1, 16'd50, 16'd50, 16'd0, 16'd0));
    plan_event(ptr_ev(CMD_PRESS, 1'b1, 1'b1, 16'd60, 16'd60, 16'd0, 16'd0));
    plan_event(ptr_ev(CMD_MOVE, 1'b1, 1'b1, 16'd40, 16'd30, 16'd0, 16'd0));
    plan_event(ptr_ev(CMD_PRESS, 1'b1, 1'b1, 16'd40, 16'd30, 16'd0, 16'd0));
    plan_event(ptr_ev(CMD_TICK, 1'b0, 1'b1, 16'd0, 16'd0, 16'd50, 16'd50));
    plan_event(ptr_ev(CMD_RELEASE, 1'b1, 1'b1, 16'd40, 16'd30, 16'd50, 16'd50));
    plan_event(ptr_ev(CMD_TICK, 1'b1, 1'b0, 16'd0, 16'd0, 16'd0, 16'd0));
    plan_event(ptr_ev(CMD_TICK, 1'b1, 1'b1, 16'd0, 16'd0, 16'd0, 16'd0));

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed table
    foreach (plan[i]) begin
      if (plan[i].is_write) begin
        settle();
        set_reg(plan[i].reg_idx, plan[i].reg_val);
      end else begin
        send_event(plan[i].ev, plan[i].pinned, plan[i].res);
      end
    end

    // random phases, each under its own limits
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin ms = 64;   dc = 1;   mx = 1000;  my = 1000;  end
        1: begin ms = 1;    dc = 0;   mx = 65535; my = 0;     end
        2: begin ms = 1023; dc = 255; mx = 65535; my = 65535; end
        3: begin ms = 20;   dc = 3;   mx = 5000;  my = 200;   end
        4: begin ms = 0;    dc = 7;   mx = 300;   my = 65535; end
        5: begin ms = 500;  dc = 50;  mx = 0;     my = 40000; end
        default: begin
          ms = $urandom_range(0, 1023);
          dc = $urandom_range(0, 255);
          mx = $urandom_range(0, 65535);
          my = $urandom_range(0, 65535);
        end
      endcase
      settle();
      set_reg(REG_MAX_SPEED, 16'(ms));
      set_reg(REG_DECEL_STEP, 16'(dc));
      set_reg(REG_SCROLL_MAX_X, 16'(mx));
      set_reg(REG_SCROLL_MAX_Y, 16'(my));
      // back-to-back stretches in some phases
      tx_quiet = (p == 2);
      rx_quiet <= (p == 2 || p == 5);
      phase_start = useful_items;
      while (useful_items - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(0, 99) < 85) flick_gesture();
        else repeat ($urandom_range(1, 4)) send_event(noise_event(), 1'b0, '0);
      end
    end

    settle();
    repeat (8) @(posedge clk);
    $display("ran %0d event beats (%0d with an effect) in %0d flick gestures, %0d register writes",
             items_sent, useful_items, gestures, cfg_writes);
    $display("compared %0d result beats over %0d distinct modes, %0d mismatches",
             results_seen, $countones(modes_seen), errors);
    if (errors == 0 && pending_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
